@@ src/byte_trie_word_set_macros.svh @@
// Assertion helpers for the byte trie word set.
// Both sample on the rising edge of clk and stay quiet while arst_n is low.
`ifndef BYTE_TRIE_WORD_SET_MACROS_SVH
`define BYTE_TRIE_WORD_SET_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BTWS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BTWS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/btws_pkg.sv @@
`default_nettype none

package btws_pkg;

	localparam int NODE_COUNT = 1024;
	localparam int FANOUT     = 256;
	localparam int BYTE_W     = 8;
	localparam int NODE_W     = $clog2(NODE_COUNT);
	localparam int CNT_W      = NODE_W + 1;
	localparam int LINK_AW    = NODE_W + BYTE_W;
	localparam int LINK_DEPTH = NODE_COUNT * FANOUT;

	// Each allocated node remembers which link created it. A link read from
	// the link store is trusted only if the node it names was allocated
	// since reset and records this very parent and byte.
	typedef struct packed {
		logic [NODE_W-1:0] parent;
		logic [BYTE_W-1:0] key;
		logic              word_end;
	} node_rec_t;

	typedef struct packed {
		logic               re;
		logic               we;
		logic [LINK_AW-1:0] addr;
		logic [NODE_W-1:0]  wdata;
	} link_req_t;

	typedef struct packed {
		logic              re;
		logic              we;
		logic [NODE_W-1:0] addr;
		node_rec_t         wdata;
	} node_req_t;

endpackage

`default_nettype wire

@@ src/btws_link_mem.sv @@
`default_nettype none

module btws_link_mem (
	input  wire                             clk,
	input  wire btws_pkg::link_req_t        req,
	output logic [btws_pkg::NODE_W-1:0]     rdata
);
	import btws_pkg::*;

	logic [NODE_W-1:0] mem [LINK_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.addr];
		end
	end

endmodule

`default_nettype wire

@@ src/btws_node_mem.sv @@
`default_nettype none

module btws_node_mem (
	input  wire                   clk,
	input  wire btws_pkg::node_req_t req,
	output btws_pkg::node_rec_t   rdata
);
	import btws_pkg::*;

	node_rec_t mem [NODE_COUNT];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.addr];
		end
	end

endmodule

`default_nettype wire

@@ src/btws_ctrl.sv @@
`default_nettype none

module btws_ctrl (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	output logic                            busy,
	input  wire                             cmd,
	input  wire                             has_byte,
	input  wire  [btws_pkg::BYTE_W-1:0]     byte_value,
	input  wire                             last,
	output logic                            strobe,
	output logic                            found,
	output logic                            status,
	output btws_pkg::link_req_t             link_req,
	input  wire  [btws_pkg::NODE_W-1:0]     link_rdata,
	output btws_pkg::node_req_t             node_req,
	input  wire btws_pkg::node_rec_t        node_rdata
);
	import btws_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LINK,
		ST_CHECK,
		ST_END_READ,
		ST_END
	} state_t;

	localparam logic [CNT_W-1:0] NODE_LIMIT = CNT_W'(NODE_COUNT);

	state_t            state_q;
	logic              cmd_q;
	logic [BYTE_W-1:0] byte_q;
	logic              last_q;
	logic [NODE_W-1:0] cur_q;
	logic [NODE_W-1:0] child_q;
	logic [CNT_W-1:0]  used_q;
	logic              missed_q;
	logic              ovf_q;
	logic              root_end_q;

	logic accept;
	logic walk_now;
	logic cand;
	logic follow;
	logic walk_miss;
	logic alloc;
	logic word_ok;
	logic mark_node;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign walk_now  = has_byte && !missed_q && !ovf_q;
	assign follow    = (node_rdata.parent == cur_q) && (node_rdata.key == byte_q);
	assign walk_miss = ((state_q == ST_LINK) && !cand) || ((state_q == ST_CHECK) && !follow);
	assign alloc     = walk_miss && cmd_q && (used_q < NODE_LIMIT);
	assign word_ok   = !missed_q && !ovf_q;
	assign mark_node = (state_q == ST_END) && cmd_q && word_ok && (cur_q != '0);

	// A link is a candidate only when it plainly names an allocated node other
	// than the root; a candidate is still checked against the node record.
	always_comb begin
		cand = 1'b0;
		if ((link_rdata != '0) && ({1'b0, link_rdata} < used_q)) begin
			cand = 1'b1;
		end
	end

	always_comb begin
		link_req.re    = accept && walk_now;
		link_req.we    = alloc;
		link_req.addr  = (state_q == ST_IDLE) ? {cur_q, byte_value} : {cur_q, byte_q};
		link_req.wdata = used_q[NODE_W-1:0];
	end

	always_comb begin
		node_req.re    = 1'b0;
		node_req.we    = 1'b0;
		node_req.addr  = cur_q;
		node_req.wdata = '{parent: cur_q, key: byte_q, word_end: 1'b0};
		if (accept && !walk_now && last) begin
			node_req.re = 1'b1;
		end else if ((state_q == ST_LINK) && cand) begin
			node_req.re   = 1'b1;
			node_req.addr = link_rdata;
		end else if (state_q == ST_END_READ) begin
			node_req.re = 1'b1;
		end else if (alloc) begin
			node_req.we   = 1'b1;
			node_req.addr = used_q[NODE_W-1:0];
		end else if (mark_node) begin
			node_req.we    = 1'b1;
			node_req.wdata = '{parent: node_rdata.parent, key: node_rdata.key, word_end: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cmd_q      <= 1'b0;
			byte_q     <= '0;
			last_q     <= 1'b0;
			cur_q      <= '0;
			child_q    <= '0;
			used_q     <= CNT_W'(1);
			missed_q   <= 1'b0;
			ovf_q      <= 1'b0;
			root_end_q <= 1'b0;
			strobe     <= 1'b0;
			found      <= 1'b0;
			status     <= 1'b0;
		end else begin
			strobe <= 1'b0;
			if (walk_miss) begin
				if (!cmd_q) begin
					missed_q <= 1'b1;
				end else if (alloc) begin
					cur_q  <= used_q[NODE_W-1:0];
					used_q <= used_q + CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q  <= cmd;
						byte_q <= byte_value;
						last_q <= last;
						if (walk_now) begin
							state_q <= ST_LINK;
						end else if (last) begin
							state_q <= ST_END;
						end
					end
				end
				ST_LINK: begin
					if (cand) begin
						child_q <= link_rdata;
						state_q <= ST_CHECK;
					end else begin
						state_q <= last_q ? ST_END_READ : ST_IDLE;
					end
				end
				ST_CHECK: begin
					if (follow) begin
						cur_q <= child_q;
					end
					state_q <= last_q ? ST_END_READ : ST_IDLE;
				end
				ST_END_READ: begin
					state_q <= ST_END;
				end
				ST_END: begin
					strobe <= 1'b1;
					if (cmd_q) begin
						found  <= 1'b0;
						status <= !word_ok;
						if (word_ok && (cur_q == '0)) begin
							root_end_q <= 1'b1;
						end
					end else begin
						status <= 1'b0;
						found  <= word_ok && ((cur_q == '0) ? root_end_q : node_rdata.word_end);
					end
					cur_q    <= '0;
					missed_q <= 1'b0;
					ovf_q    <= 1'b0;
					state_q  <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ src/byte_trie_word_set.sv @@
// Byte trie word set: a dictionary of byte strings held as a 256-way trie.
// Input channel: an item is transferred at a rising edge where start is high
// and busy is low. Each item carries cmd (0 lookup, 1 insert), has_byte,
// byte_value and last; a word is a run of items ending with last high, and
// an item with has_byte low moves nothing (so an empty word tests the root).
// Result channel: on the final item of each word one result is transferred
// while strobe is high for a single cycle: found for a lookup, status for an
// insert (1 when the node store ran out or the word was abandoned).
// The receiver cannot stall; a result is simply presented for one cycle.
// Sequence: a byte whose link exists takes a link read, then a read of the
// child's node record to confirm it; a missing link is allocated as soon as
// the link data returns, or once the record data fails to confirm it; a
// non-final item that walks no byte leaves the sequencer idle. A final item
// adds the node record read and the end-of-word update, or only the update
// if it walks no byte, since its read goes out with the transfer. Strobe is
// high in the cycle after the update, with busy low. These steps come from
// the chain of dependent reads through both stores, each one registered.
// Reset: asynchronous, active low. It clears the control state at once and
// needs no clearing pass: links are validated against the node count and
// each node's recorded parent, so stale memory contents are never believed.
`default_nettype none

module byte_trie_word_set (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           start,
	output logic                          busy,
	input  wire                           cmd,
	input  wire                           has_byte,
	input  wire  [btws_pkg::BYTE_W-1:0]   byte_value,
	input  wire                           last,
	output logic                          strobe,
	output logic                          found,
	output logic                          status
);
	import btws_pkg::*;

	// Request and read data of the link store (one entry per node and byte).
	link_req_t         link_req;
	logic [NODE_W-1:0] link_rdata;

	// Request and read data of the node record store.
	node_req_t node_req;
	node_rec_t node_rdata;

	// The sequencer walks one byte at a time and owns both stores' ports.
	btws_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.has_byte   (has_byte),
		.byte_value (byte_value),
		.last       (last),
		.strobe     (strobe),
		.found      (found),
		.status     (status),
		.link_req   (link_req),
		.link_rdata (link_rdata),
		.node_req   (node_req),
		.node_rdata (node_rdata)
	);

	btws_link_mem u_link_mem (
		.clk   (clk),
		.req   (link_req),
		.rdata (link_rdata)
	);

	btws_node_mem u_node_mem (
		.clk   (clk),
		.req   (node_req),
		.rdata (node_rdata)
	);

endmodule

`default_nettype wire

@@ src/btws_checker.sv @@
`default_nettype none

`include "byte_trie_word_set_macros.svh"

module btws_checker (
	input wire                         clk,
	input wire                         arst_n,
	input wire                         start,
	input wire                         busy,
	input wire                         last,
	input wire                         strobe,
	input wire                         found,
	input wire                         status
);

	// A result answers either a lookup or an insert, never both.
	`BTWS_ASSERT_SAME(a_one_answer, strobe, !(found && status), "found and status both set")

	// Results are single-cycle pulses, as the end-of-word state always returns to idle.
	`BTWS_ASSERT_NEXT(a_strobe_pulse, strobe, !strobe, "strobe held for two cycles")

	// A result only appears once the sequencer is back at rest.
	`BTWS_ASSERT_SAME(a_strobe_idle, strobe, !busy, "strobe while busy")

	// The final item of a word always keeps the block busy for the finish.
	`BTWS_ASSERT_NEXT(a_last_busy, start && !busy && last, busy, "final item not processed")

endmodule

bind byte_trie_word_set btws_checker u_btws_checker (.*);

`default_nettype wire

@@ dv/byte_trie_word_set_tb.sv @@
`default_nettype none

// Testbench for the byte trie word set.
//
// Words are sent one byte per input transfer. A queue of pending items is
// filled at time zero, and a clocked driver hands them to the block in bursts
// with random gaps between them. A clocked monitor takes every result strobe
// and compares it with the oldest verdict still waiting. The verdicts come
// from a trie kept here in the testbench. It is advanced by each item at the
// edge that transfers the item, so it always sees exactly what the block saw.
module byte_trie_word_set_tb;
	import btws_pkg::*;

	// Cycles without any transfer, in or out, before the run is declared hung.
	// The limit lies far beyond the longest item together with any sender gap.
	localparam int QUIET_LIMIT = 2000;
	localparam int ITEM_TARGET = 1450;
	// Bytes of fresh insert words to send before the mix turns towards a full store.
	// Fresh bytes almost always allocate, so this comfortably exhausts the store.
	localparam int FILL_BYTES  = 1080;
	localparam int SAVE_SLOTS  = 64;
	localparam int WORD_MAX    = 48;
	localparam int SETTLE      = 16;

	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_INSERT = 1'b1
	} trie_op_t;

	typedef struct packed {
		trie_op_t          op;
		logic              has_byte;
		logic [BYTE_W-1:0] byte_value;
		logic              last;
	} word_item_t;

	typedef struct packed {
		logic found;
		logic status;
	} word_verdict_t;

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              start      = 1'b0;
	logic              cmd        = 1'b0;
	logic              has_byte   = 1'b0;
	logic [BYTE_W-1:0] byte_value = '0;
	logic              last       = 1'b0;
	logic              busy;
	logic              strobe;
	logic              found;
	logic              status;

	byte_trie_word_set DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.has_byte   (has_byte),
		.byte_value (byte_value),
		.last       (last),
		.strobe     (strobe),
		.found      (found),
		.status     (status)
	);

	always #1 clk = ~clk;

	// Items waiting to be sent, and verdicts waiting for their result strobe.
	word_item_t    pending_items [$];
	word_verdict_t verdict_q [$];

	// The testbench's own trie. Links live in a sparse map keyed by
	// node * 256 + byte; a key that is absent is a missing link.
	logic [NODE_W-1:0] link_map [int];
	logic              word_mark [NODE_COUNT];
	logic [NODE_W-1:0] path_node;
	bit                path_missed;
	bit                path_full;
	int                node_total;

	int mismatches = 0;

	// Applies one transferred item to the trie and, on the final item of a
	// word, queues the verdict that the block must report.
	function automatic void trie_apply(input word_item_t it);
		int            slot;
		word_verdict_t v;
		if (it.has_byte && !path_missed && !path_full) begin
			slot = int'(path_node) * FANOUT + int'(it.byte_value);
			if (link_map.exists(slot)) begin
				path_node = link_map[slot];
			end else if (it.op == OP_LOOKUP) begin
				path_missed = 1'b1;
			end else if (node_total >= NODE_COUNT) begin
				// The store is out of nodes. Whatever this word allocated so far
				// stays in place, but the word itself will not be marked.
				path_full = 1'b1;
			end else begin
				link_map[slot] = NODE_W'(node_total);
				path_node      = NODE_W'(node_total);
				node_total++;
			end
		end
		if (it.last) begin
			v = '0;
			if (it.op == OP_INSERT) begin
				if (path_missed || path_full)
					v.status = 1'b1;
				else
					word_mark[path_node] = 1'b1;
			end else begin
				v.found = !path_missed && !path_full && word_mark[path_node];
			end
			verdict_q.push_back(v);
			// Every word ends back at the root with a clean slate.
			path_node   = '0;
			path_missed = 1'b0;
			path_full   = 1'b0;
		end
	endfunction

	task automatic note_mismatch(input string what, input word_verdict_t want,
			input bit have_want);
		mismatches++;
		if (mismatches <= 10) begin
			if (have_want)
				$display("%s: expected found=%0b status=%0b, got found=%0b status=%0b",
					what, want.found, want.status, found, status);
			else
				$display("%s: got found=%0b status=%0b", what, found, status);
		end
	endtask

	// ---------------------------------------------------------------------
	// Driver. The slot is free when no item is offered or when the offered
	// item is transferred at this edge. Each burst ends with a random gap.
	// ---------------------------------------------------------------------
	int         gap_left   = 0;
	int         burst_left = 0;
	word_item_t next_item;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start      <= 1'b0;
			cmd        <= 1'b0;
			has_byte   <= 1'b0;
			byte_value <= '0;
			last       <= 1'b0;
		end else begin
			// The ports still hold the item offered during the cycle just ended.
			if (start && !busy)
				trie_apply('{op: trie_op_t'(cmd), has_byte: has_byte,
					byte_value: byte_value, last: last});
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending_items.size() != 0) begin
					next_item   = pending_items.pop_front();
					cmd        <= next_item.op;
					has_byte   <= next_item.has_byte;
					byte_value <= next_item.byte_value;
					last       <= next_item.last;
					start      <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 40);
						gap_left   = $urandom_range(1, 12);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Monitor. A result is present for one cycle only, so every strobe is a
	// transfer and must match the oldest verdict.
	// ---------------------------------------------------------------------
	word_verdict_t want_verdict;

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (verdict_q.size() == 0) begin
				note_mismatch("Result with no word outstanding", '0, 1'b0);
			end else begin
				want_verdict = verdict_q.pop_front();
				if (found !== want_verdict.found || status !== want_verdict.status)
					note_mismatch("Result mismatch", want_verdict, 1'b1);
			end
		end
	end

	// Watchdog: any transfer in either direction restarts the count.
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || strobe)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus construction.
	// ---------------------------------------------------------------------
	logic [BYTE_W-1:0] word_buf [WORD_MAX];
	int                word_len = 0;
	logic [BYTE_W-1:0] saved_bytes [SAVE_SLOTS][WORD_MAX];
	int                saved_len [SAVE_SLOTS];
	int                saved_count = 0;
	int                items_made = 0;
	int                fresh_bytes = 0;

	task automatic put_item(input trie_op_t op, input logic with_byte,
			input logic [BYTE_W-1:0] b, input logic fin);
		pending_items.push_back('{op: op, has_byte: with_byte, byte_value: b, last: fin});
		items_made++;
	endtask

	// Sends the word in word_buf. With mixed set, each byte item picks its own
	// operation; with blanks set, byte-less items are slipped in, and the word
	// may be closed by a byte-less final item.
	task automatic emit_word(input trie_op_t op, input bit mixed, input bit blanks);
		bit       blank_end;
		trie_op_t this_op;
		blank_end = blanks && (word_len > 0) && ($urandom_range(0, 2) == 0);
		if (word_len == 0)
			put_item(op, 1'b0, BYTE_W'($urandom), 1'b1);
		for (int i = 0; i < word_len; i++) begin
			this_op = mixed ? trie_op_t'($urandom_range(0, 1)) : op;
			if (blanks && $urandom_range(0, 4) == 0)
				put_item(this_op, 1'b0, BYTE_W'($urandom), 1'b0);
			put_item(this_op, 1'b1, word_buf[i], (i == word_len - 1) && !blank_end);
		end
		if (blank_end)
			put_item(op, 1'b0, BYTE_W'($urandom), 1'b1);
	endtask

	task automatic fresh_word(input int len);
		word_len = len;
		for (int i = 0; i < len; i++)
			word_buf[i] = BYTE_W'($urandom_range(0, 255));
	endtask

	task automatic keep_word();
		int slot;
		if (saved_count < SAVE_SLOTS) begin
			slot = saved_count;
			saved_count++;
		end else begin
			slot = $urandom_range(0, SAVE_SLOTS - 1);
		end
		saved_len[slot] = word_len;
		for (int i = 0; i < word_len; i++)
			saved_bytes[slot][i] = word_buf[i];
	endtask

	task automatic recall_word();
		int slot;
		slot     = $urandom_range(0, saved_count - 1);
		word_len = saved_len[slot];
		for (int i = 0; i < word_len; i++)
			word_buf[i] = saved_bytes[slot][i];
	endtask

	int pick;

	initial begin
		for (int n = 0; n < NODE_COUNT; n++)
			word_mark[n] = 1'b0;
		path_node   = '0;
		path_missed = 1'b0;
		path_full   = 1'b0;
		node_total  = 1;

		// Directed words. The empty word tests and marks the root.
		put_item(OP_LOOKUP, 1'b0, 8'hA5, 1'b1);
		put_item(OP_INSERT, 1'b0, 8'h5A, 1'b1);
		put_item(OP_LOOKUP, 1'b0, 8'hFF, 1'b1);
		// Extreme byte values, then the word, a prefix of it and a miss whose
		// later bytes must be ignored.
		put_item(OP_INSERT, 1'b1, 8'h00, 1'b0);
		put_item(OP_INSERT, 1'b1, 8'hFF, 1'b1);
		put_item(OP_LOOKUP, 1'b1, 8'h00, 1'b0);
		put_item(OP_LOOKUP, 1'b1, 8'hFF, 1'b1);
		put_item(OP_LOOKUP, 1'b1, 8'h00, 1'b1);
		put_item(OP_LOOKUP, 1'b1, 8'hFF, 1'b0);
		put_item(OP_LOOKUP, 1'b1, 8'h00, 1'b1);
		// A byte-less item in the middle of a word moves nothing.
		put_item(OP_INSERT, 1'b1, 8'h80, 1'b0);
		put_item(OP_INSERT, 1'b0, 8'h33, 1'b0);
		put_item(OP_INSERT, 1'b1, 8'h7F, 1'b1);
		put_item(OP_LOOKUP, 1'b1, 8'h80, 1'b0);
		put_item(OP_LOOKUP, 1'b1, 8'h7F, 1'b1);
		// Mixed operations: a lookup step along an existing link, then an
		// insert that allocates; and a lookup miss that spoils a final insert.
		put_item(OP_LOOKUP, 1'b1, 8'h00, 1'b0);
		put_item(OP_INSERT, 1'b1, 8'h01, 1'b1);
		put_item(OP_LOOKUP, 1'b1, 8'h55, 1'b0);
		put_item(OP_INSERT, 1'b1, 8'h01, 1'b1);
		put_item(OP_LOOKUP, 1'b1, 8'h00, 1'b0);
		put_item(OP_LOOKUP, 1'b1, 8'h01, 1'b1);

		// Random words. Long fresh inserts first, so that the node store runs
		// out part way through; after that the mix turns to inserts that hit
		// the full store, lookups and re-inserts of known words, and noise.
		while (items_made < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (fresh_bytes < FILL_BYTES) begin
				if (pick < 82) begin
					fresh_word($urandom_range(16, WORD_MAX));
					fresh_bytes += word_len;
					keep_word();
					emit_word(OP_INSERT, 1'b0, $urandom_range(0, 7) == 0);
				end else if (pick < 92 && saved_count > 0) begin
					recall_word();
					emit_word(OP_LOOKUP, 1'b0, $urandom_range(0, 1));
				end else begin
					fresh_word($urandom_range(0, 4));
					emit_word(trie_op_t'($urandom_range(0, 1)), $urandom_range(0, 1),
						$urandom_range(0, 1));
				end
			end else begin
				if (pick < 20) begin
					fresh_word($urandom_range(1, 6));
					emit_word(OP_INSERT, 1'b0, $urandom_range(0, 3) == 0);
				end else if (pick < 55 && saved_count > 0) begin
					recall_word();
					// Sometimes a prefix or an extension of a known word.
					case ($urandom_range(0, 3))
						0: begin
							word_len = $urandom_range(0, word_len);
						end
						1: begin
							if (word_len < WORD_MAX) begin
								word_buf[word_len] = BYTE_W'($urandom);
								word_len++;
							end
						end
						default: ;
					endcase
					emit_word(OP_LOOKUP, 1'b0, $urandom_range(0, 3) == 0);
				end else if (pick < 70 && saved_count > 0) begin
					recall_word();
					emit_word(OP_INSERT, 1'b0, $urandom_range(0, 3) == 0);
				end else begin
					fresh_word($urandom_range(0, 4));
					emit_word(trie_op_t'($urandom_range(0, 1)), $urandom_range(0, 1),
						$urandom_range(0, 1));
				end
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for the last transfer in, then for the last result out.
		while (pending_items.size() != 0 || start)
			@(posedge clk);
		while (verdict_q.size() != 0)
			@(posedge clk);
		// Then wait out the settle time to catch any stray strobe.
		repeat (SETTLE) @(posedge clk);

		if (mismatches == 0 && verdict_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+src
src/btws_pkg.sv
src/btws_link_mem.sv
src/btws_node_mem.sv
src/btws_ctrl.sv
src/byte_trie_word_set.sv
src/btws_checker.sv
dv/byte_trie_word_set_tb.sv
